// ===== design/rc4_variant_stream_decrypt_unit_defines.svh =====
// Assertion macros shared by the checker of the stream decrypt unit.
// Needs clk and rst in the scope where each macro is used.
`ifndef RC4_VARIANT_STREAM_DECRYPT_UNIT_DEFINES_SVH
`define RC4_VARIANT_STREAM_DECRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RC4VSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define RC4VSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rc4vsd_pkg.sv =====
// Types and constants of the stream decrypt unit.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps
package rc4vsd_pkg;

  localparam int BOX_SIZE = 256;
  localparam int BOX_AW   = 8;

  // Request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_BUILD   = 2'd1;
  localparam logic [1:0] REQ_DECRYPT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_BUILT  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] key_index;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] plain_byte;
  } res_item_t;

endpackage

// ===== design/rc4_variant_stream_decrypt_unit.sv =====
// Top level of the RC4-schedule stream decrypt unit.
// Depends on rc4vsd_pkg and rc4vsd_ram.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready  | in_item  (req_item_t)
//   out     | out       | out_valid / out_ready| out_item (res_item_t)
//   cfg     | in        | cfg_we               | cfg_wdata (key length)
//
// A key load is written to the key store as it is taken; a decrypt reads
// the box three times; a build writes the identity, then swaps, paced by
// the box RAM: one identity write a cycle and four accesses per swap.
// Reset (rst, synchronous) clears the sequencer, the output slot, the
// stream position and the box-ready flag; the RAMs keep their contents.
// A finished result waits in the output register while the next item is
// taken; the block stalls only when a second result finds the slot full.
`timescale 1ns / 1ps
module rc4_variant_stream_decrypt_unit
  import rc4vsd_pkg::*;
#(
  parameter int KEY_MAX_LEN = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int KS_AW = (KEY_MAX_LEN > 1) ? $clog2(KEY_MAX_LEN) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD_N, S_RD_P, S_WR_N, S_WR_P,
    S_DEC_A, S_DEC_B, S_DEC_C, S_DEC_D, S_EMIT
  } state_t;

  state_t            state;
  logic [7:0]        key_length;
  logic [7:0]        pos;
  logic              box_ready;
  logic [7:0]        n;        // sweep counter for init and swaps
  logic [KS_AW-1:0]  koff;     // key offset, wraps at key length
  logic [7:0]        prev;
  logic [7:0]        held;
  logic [7:0]        pick;
  logic [7:0]        jpos;
  logic [7:0]        a_val;
  logic [7:0]        dbyte;
  res_item_t         res;

  // Box RAM port
  logic              box_we;
  logic [BOX_AW-1:0] box_waddr;
  logic [7:0]        box_wdata;
  logic [BOX_AW-1:0] box_raddr;
  logic [7:0]        box_rdata;

  // Key store port
  logic              key_we;
  logic [KS_AW-1:0]  key_raddr;
  logic [7:0]        key_rdata;

  logic              accept;
  logic [8:0]        len_eff;
  logic [7:0]        pick_c;
  logic              koff_wrap;
  logic              emit_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign key_we   = accept && (in_item.req_type == REQ_LOAD) &&
                    ({2'b00, in_item.key_index} < 9'(KEY_MAX_LEN));

  // Clamp the key length into 1..KEY_MAX_LEN
  always_comb begin
    if (key_length == 8'd0) begin
      len_eff = 9'd1;
    end else if ({1'b0, key_length} > 9'(KEY_MAX_LEN)) begin
      len_eff = 9'(KEY_MAX_LEN);
    end else begin
      len_eff = {1'b0, key_length};
    end
  end

  assign koff_wrap = (9'(koff) + 9'd1) >= len_eff;
  assign pick_c    = box_rdata + prev + key_rdata;
  assign emit_go   = !out_valid || out_ready;

  // Address and write selection for the shared box port
  always_comb begin
    box_we    = 1'b0;
    box_waddr = n;
    box_wdata = n;
    box_raddr = n;
    key_raddr = koff;
    case (state)
      S_INIT: begin
        box_we = 1'b1;
      end
      S_RD_P: begin
        box_raddr = pick_c;
      end
      S_WR_N: begin
        box_we    = 1'b1;
        box_wdata = box_rdata;
      end
      S_WR_P: begin
        box_we    = 1'b1;
        box_waddr = pick;
        box_wdata = held;
      end
      S_DEC_A: begin
        box_raddr = jpos;
      end
      S_DEC_B: begin
        box_raddr = box_rdata + jpos;
      end
      S_DEC_C: begin
        box_raddr = a_val + box_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_length <= 8'd1;
      pos        <= 8'd0;
      box_ready  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_length <= cfg_wdata;
      end
      // Drop the result once taken, unless the emit state reloads the slot
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            dbyte <= in_item.data_byte;
            jpos  <= pos + 8'd1;
            case (in_item.req_type)
              REQ_BUILD: begin
                n     <= 8'd0;
                state <= S_INIT;
              end
              REQ_DECRYPT: begin
                if (box_ready) begin
                  state <= S_DEC_A;
                end else begin
                  res   <= '{result_kind: KIND_REJECT, plain_byte: 8'd0};
                  state <= S_EMIT;
                end
              end
              default: begin
                // key loads write the store directly; unused codes are dropped
              end
            endcase
          end
        end
        S_INIT: begin
          // Write the identity, then start the swaps with cleared indices
          n <= n + 8'd1;
          if (n == 8'(BOX_SIZE - 1)) begin
            koff  <= '0;
            prev  <= 8'd0;
            state <= S_RD_N;
          end
        end
        S_RD_N: begin
          state <= S_RD_P;
        end
        S_RD_P: begin
          held  <= box_rdata;
          pick  <= pick_c;
          koff  <= koff_wrap ? '0 : koff + KS_AW'(1);
          state <= S_WR_N;
        end
        S_WR_N: begin
          state <= S_WR_P;
        end
        S_WR_P: begin
          prev <= pick;
          n    <= n + 8'd1;
          if (n == 8'(BOX_SIZE - 1)) begin
            box_ready <= 1'b1;
            pos       <= 8'd0;
            res       <= '{result_kind: KIND_BUILT, plain_byte: 8'd0};
            state     <= S_EMIT;
          end else begin
            state <= S_RD_N;
          end
        end
        S_DEC_A: begin
          state <= S_DEC_B;
        end
        S_DEC_B: begin
          a_val <= box_rdata;
          state <= S_DEC_C;
        end
        S_DEC_C: begin
          state <= S_DEC_D;
        end
        S_DEC_D: begin
          pos   <= jpos;
          res   <= '{result_kind: KIND_PLAIN, plain_byte: dbyte ^ box_rdata};
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output slot is free
          if (emit_go) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rc4vsd_ram #(
    .WIDTH (8),
    .DEPTH (BOX_SIZE)
  ) u_box (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rdata)
  );

  rc4vsd_ram #(
    .WIDTH (8),
    .DEPTH (KEY_MAX_LEN)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (KS_AW'(in_item.key_index)),
    .wdata (in_item.data_byte),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

endmodule

// ===== design/rc4vsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rc4vsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rc4vsd_checker.sv =====
// Port-level checker of the stream decrypt unit, bound to the top level.
// Depends on rc4vsd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rc4_variant_stream_decrypt_unit_defines.svh"
module rc4vsd_checker
  import rc4vsd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input req_item_t in_item,
  input logic      out_valid,
  input logic      out_ready,
  input res_item_t out_item
);

  `RC4VSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "output item changed while stalled")
  `RC4VSD_ASSERT_NEXT(a_busy_after_work, in_valid && in_ready && (in_item.req_type == REQ_BUILD || in_item.req_type == REQ_DECRYPT), !in_ready, "block took a second item while working")
  `RC4VSD_ASSERT_NOW(a_zero_byte, out_valid && out_item.result_kind != KIND_PLAIN, out_item.plain_byte == 8'd0, "status result carries a nonzero byte")
  `RC4VSD_ASSERT_NOW(a_kind_legal, out_valid, out_item.result_kind == KIND_PLAIN || out_item.result_kind == KIND_BUILT || out_item.result_kind == KIND_REJECT, "unknown result kind")

endmodule

bind rc4_variant_stream_decrypt_unit rc4vsd_checker u_checker (.*);
